[hw/rtl/sha1sh_pkg.sv]
// Shared types, constants and state encodings for the SHA-1 stream hasher.
`timescale 1ns / 1ps

package sha1sh_pkg;

    localparam int unsigned COUNT_W = 61;

    typedef logic [31:0] word_t;
    typedef word_t [0:4] chain_t;

    localparam chain_t INIT_CHAIN = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_ROUND0 = 32'h5A827999;
    localparam word_t K_ROUND1 = 32'h6ED9EBA1;
    localparam word_t K_ROUND2 = 32'h8F1BBCDC;
    localparam word_t K_ROUND3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARKER      = 8'h80;
    localparam logic [5:0] BLOCK_LAST_BYTE = 6'h3F;
    localparam logic [1:0] WORD_LAST_BYTE  = 2'd3;
    localparam logic [3:0] LEN_HI_WORD     = 4'd14;
    localparam logic [3:0] LEN_LO_WORD     = 4'd15;
    localparam logic [2:0] LAST_OUT        = 3'd4;
    localparam logic [6:0] SCHED_WORDS     = 7'd16;
    localparam logic [6:0] ROUND_LAST      = 7'd79;
    localparam logic [6:0] PHASE1_START    = 7'd20;
    localparam logic [6:0] PHASE2_START    = 7'd40;
    localparam logic [6:0] PHASE3_START    = 7'd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP_START,
        ST_COMP_WAIT,
        ST_OUT
    } hs_state_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINISH
    } core_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

[hw/rtl/sha1sh_core.sv]
// SHA-1 compression engine: one round per cycle, message schedule in a 16-word window.
`timescale 1ns / 1ps

module sha1sh_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sha1sh_pkg::chain_t    chain_in,
    output logic [3:0]            rd_addr,
    input  logic [31:0]           rd_data,
    output sha1sh_pkg::chain_t    chain_out,
    output sha1sh_pkg::core_stat_t stat
);

    sha1sh_pkg::core_state_t state_reg, state_next;
    logic [6:0]  round_reg, round_next;
    logic [6:0]  round_plus1;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] win_reg [16];
    logic [31:0] sched_x;
    logic [31:0] w_cur;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    assign round_plus1 = round_reg + 7'd1;
    assign sched_x     = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];

    always_comb
    begin
        if (round_reg < sha1sh_pkg::SCHED_WORDS)
        begin
            w_cur = rd_data;
        end
        else
        begin
            w_cur = {sched_x[30:0], sched_x[31]};
        end

        if (round_reg < sha1sh_pkg::PHASE1_START)
        begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = sha1sh_pkg::K_ROUND0;
        end
        else if (round_reg < sha1sh_pkg::PHASE2_START)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K_ROUND1;
        end
        else if (round_reg < sha1sh_pkg::PHASE3_START)
        begin
            f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k_val = sha1sh_pkg::K_ROUND2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K_ROUND3;
        end

        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;
    end

    // Prefetch the next schedule word; the idle address primes word 0.
    assign rd_addr = (state_reg == sha1sh_pkg::CORE_IDLE) ? 4'd0 : round_plus1[3:0];

    assign chain_out[0] = chain_in[0] + a_reg;
    assign chain_out[1] = chain_in[1] + b_reg;
    assign chain_out[2] = chain_in[2] + c_reg;
    assign chain_out[3] = chain_in[3] + d_reg;
    assign chain_out[4] = chain_in[4] + e_reg;

    assign stat.busy = (state_reg != sha1sh_pkg::CORE_IDLE);
    assign stat.done = (state_reg == sha1sh_pkg::CORE_FINISH);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            sha1sh_pkg::CORE_IDLE:
            begin
                if (start)
                begin
                    state_next = sha1sh_pkg::CORE_ROUND;
                    round_next = 7'd0;
                end
            end
            sha1sh_pkg::CORE_ROUND:
            begin
                round_next = round_plus1;
                if (round_reg == sha1sh_pkg::ROUND_LAST)
                begin
                    state_next = sha1sh_pkg::CORE_FINISH;
                end
            end
            sha1sh_pkg::CORE_FINISH:
            begin
                state_next = sha1sh_pkg::CORE_IDLE;
            end
            default:
            begin
                state_next = sha1sh_pkg::CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1sh_pkg::CORE_IDLE;
            round_reg <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    // Working variables and schedule window.
    always_ff @(posedge clk)
    begin
        if (state_reg == sha1sh_pkg::CORE_IDLE && start)
        begin
            a_reg <= chain_in[0];
            b_reg <= chain_in[1];
            c_reg <= chain_in[2];
            d_reg <= chain_in[3];
            e_reg <= chain_in[4];
        end
        else if (state_reg == sha1sh_pkg::CORE_ROUND)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_cur;
        end
    end

endmodule

[hw/rtl/sha1_stream_hasher_top.sv]
// Top level of the SHA-1 stream hasher: byte packing, padding, block memory, digest output.
`timescale 1ns / 1ps

// SHA-1 over a byte stream. Each input transaction carries at most one message
// byte (tuser high marks a valid byte in tdata) and tlast ends the message after
// that byte; tlast with tuser low ends the message with no byte, which also
// hashes the empty message. Bytes are packed big-endian into 32-bit words and
// written to a 16-word block memory; the 64th byte of a block starts the
// compression engine, which reads the block back one word per cycle and runs
// one round per cycle. While a full block is compressed (start, 80 rounds,
// chaining add) no byte is taken. At end of message the pad writer fills
// the block from the marker word up to word 15, one word at a time and at
// most 16 words, then compresses; when the marker lands in word 14 or 15 a
// second block is padded in full and compressed as well. The digest then
// leaves as five output transactions, word 0 (most significant) first, tuser
// giving the word position and tlast flagging word 4. After the last word the
// hasher is back at its initial state and takes the next message. Input and
// output are never active at the same time.

module sha1_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sha1sh_pkg::hs_state_t state_reg, state_next;

    logic [sha1sh_pkg::COUNT_W-1:0] count_reg, count_next;
    sha1sh_pkg::chain_t chain_reg, chain_next;
    logic [31:0] word_reg, word_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        fin_pending_reg, fin_pending_next;
    logic        pad_phase_reg, pad_phase_next;
    logic        len_ok_reg, len_ok_next;
    logic        mark_pending_reg, mark_pending_next;

    // Block memory: 16 words, one write and one registered read per cycle.
    logic [31:0] blk_mem [16];
    logic [31:0] mem_rdata_reg;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;

    logic                   core_start;
    logic [3:0]             core_rd_addr;
    sha1sh_pkg::chain_t     core_chain;
    sha1sh_pkg::core_stat_t core_stat;

    logic                   in_accept;
    logic [1:0]             slot;
    logic [3:0]             cur_word_idx;
    logic [sha1sh_pkg::COUNT_W-1:0] count_inc;
    logic [31:0]            byte_word;
    logic [31:0]            mark_word;
    logic [31:0]            pad_word;
    logic [63:0]            bit_len;

    assign s_axis_tready = (state_reg == sha1sh_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign slot          = count_reg[1:0];
    assign cur_word_idx  = count_reg[5:2];
    assign count_inc     = count_reg + {{(sha1sh_pkg::COUNT_W-1){1'b0}}, 1'b1};
    assign bit_len       = {count_reg, 3'b000};

    // Merge the incoming byte into the word being assembled.
    always_comb
    begin
        case (slot)
            2'd0:    byte_word = {s_axis_tdata, word_reg[23:0]};
            2'd1:    byte_word = {word_reg[31:24], s_axis_tdata, word_reg[15:0]};
            2'd2:    byte_word = {word_reg[31:16], s_axis_tdata, word_reg[7:0]};
            default: byte_word = {word_reg[31:8], s_axis_tdata};
        endcase
    end

    // Word that carries the end marker: message bytes above, zeros below.
    always_comb
    begin
        case (slot)
            2'd0:    mark_word = {sha1sh_pkg::PAD_MARKER, 24'h0};
            2'd1:    mark_word = {word_reg[31:24], sha1sh_pkg::PAD_MARKER, 16'h0};
            2'd2:    mark_word = {word_reg[31:16], sha1sh_pkg::PAD_MARKER, 8'h0};
            default: mark_word = {word_reg[31:8], sha1sh_pkg::PAD_MARKER};
        endcase
    end

    always_comb
    begin
        if (mark_pending_reg)
        begin
            pad_word = mark_word;
        end
        else if (len_ok_reg && pad_idx_reg == sha1sh_pkg::LEN_HI_WORD)
        begin
            pad_word = bit_len[63:32];
        end
        else if (len_ok_reg && pad_idx_reg == sha1sh_pkg::LEN_LO_WORD)
        begin
            pad_word = bit_len[31:0];
        end
        else
        begin
            pad_word = 32'h0;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        chain_next        = chain_reg;
        word_next         = word_reg;
        pad_idx_next      = pad_idx_reg;
        out_idx_next      = out_idx_reg;
        fin_pending_next  = fin_pending_reg;
        pad_phase_next    = pad_phase_reg;
        len_ok_next       = len_ok_reg;
        mark_pending_next = mark_pending_reg;
        mem_we            = 1'b0;
        mem_waddr         = cur_word_idx;
        mem_wdata         = byte_word;
        core_start        = 1'b0;
        m_axis_tvalid     = 1'b0;

        unique case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser)
                    begin
                        word_next  = byte_word;
                        count_next = count_inc;
                        // Commit the word once its last byte arrives.
                        mem_we     = (slot == sha1sh_pkg::WORD_LAST_BYTE);
                    end
                    if (s_axis_tuser && count_reg[5:0] == sha1sh_pkg::BLOCK_LAST_BYTE)
                    begin
                        state_next       = sha1sh_pkg::ST_COMP_START;
                        fin_pending_next = s_axis_tlast;
                        pad_phase_next   = 1'b0;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next        = sha1sh_pkg::ST_PAD;
                        pad_phase_next    = 1'b1;
                        mark_pending_next = 1'b1;
                        pad_idx_next      = count_next[5:2];
                        len_ok_next       = (count_next[5:2] < sha1sh_pkg::LEN_HI_WORD);
                    end
                end
            end
            sha1sh_pkg::ST_PAD:
            begin
                mem_we            = 1'b1;
                mem_waddr         = pad_idx_reg;
                mem_wdata         = pad_word;
                mark_pending_next = 1'b0;
                if (pad_idx_reg == sha1sh_pkg::LEN_LO_WORD)
                begin
                    state_next = sha1sh_pkg::ST_COMP_START;
                end
                else
                begin
                    pad_idx_next = pad_idx_reg + 4'd1;
                end
            end
            sha1sh_pkg::ST_COMP_START:
            begin
                core_start = 1'b1;
                state_next = sha1sh_pkg::ST_COMP_WAIT;
            end
            sha1sh_pkg::ST_COMP_WAIT:
            begin
                if (core_stat.done)
                begin
                    chain_next = core_chain;
                    if (!pad_phase_reg)
                    begin
                        if (fin_pending_reg)
                        begin
                            // Message ended on a block boundary: pad a fresh block.
                            state_next        = sha1sh_pkg::ST_PAD;
                            pad_phase_next    = 1'b1;
                            fin_pending_next  = 1'b0;
                            mark_pending_next = 1'b1;
                            pad_idx_next      = cur_word_idx;
                            len_ok_next       = (cur_word_idx < sha1sh_pkg::LEN_HI_WORD);
                        end
                        else
                        begin
                            state_next = sha1sh_pkg::ST_IDLE;
                        end
                    end
                    else if (!len_ok_reg)
                    begin
                        // Marker spilled past the length field: one more block.
                        state_next        = sha1sh_pkg::ST_PAD;
                        len_ok_next       = 1'b1;
                        mark_pending_next = 1'b0;
                        pad_idx_next      = 4'd0;
                    end
                    else
                    begin
                        state_next   = sha1sh_pkg::ST_OUT;
                        out_idx_next = 3'd0;
                    end
                end
            end
            sha1sh_pkg::ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (out_idx_reg == sha1sh_pkg::LAST_OUT)
                    begin
                        // Digest delivered: return to the initial hash state.
                        state_next       = sha1sh_pkg::ST_IDLE;
                        chain_next       = sha1sh_pkg::INIT_CHAIN;
                        count_next       = '0;
                        pad_phase_next   = 1'b0;
                        fin_pending_next = 1'b0;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = sha1sh_pkg::ST_IDLE;
            end
        endcase
    end

    // Digest word select from the chaining registers.
    always_comb
    begin
        case (out_idx_reg)
            3'd0:    m_axis_tdata = chain_reg[0];
            3'd1:    m_axis_tdata = chain_reg[1];
            3'd2:    m_axis_tdata = chain_reg[2];
            3'd3:    m_axis_tdata = chain_reg[3];
            default: m_axis_tdata = chain_reg[4];
        endcase
    end

    assign m_axis_tuser = out_idx_reg;
    assign m_axis_tlast = (out_idx_reg == sha1sh_pkg::LAST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sha1sh_pkg::ST_IDLE;
            count_reg        <= '0;
            chain_reg        <= sha1sh_pkg::INIT_CHAIN;
            pad_idx_reg      <= 4'd0;
            out_idx_reg      <= 3'd0;
            fin_pending_reg  <= 1'b0;
            pad_phase_reg    <= 1'b0;
            len_ok_reg       <= 1'b0;
            mark_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            chain_reg        <= chain_next;
            pad_idx_reg      <= pad_idx_next;
            out_idx_reg      <= out_idx_next;
            fin_pending_reg  <= fin_pending_next;
            pad_phase_reg    <= pad_phase_next;
            len_ok_reg       <= len_ok_next;
            mark_pending_reg <= mark_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            blk_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= blk_mem[core_rd_addr];
    end

    sha1sh_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .chain_in  (chain_reg),
        .rd_addr   (core_rd_addr),
        .rd_data   (mem_rdata_reg),
        .chain_out (core_chain),
        .stat      (core_stat)
    );

    // Input and output sides never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output active together");

    // The block memory must not change under a running compression.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !core_stat.busy)
        else $error("block memory written during compression");

    // Completion is only seen while waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> state_reg == sha1sh_pkg::ST_COMP_WAIT)
        else $error("compression done outside wait state");

    // A start always launches the engine.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha1sh_pkg::ST_COMP_START |=> core_stat.busy)
        else $error("compression engine did not start");

    // Final digest word hands back a cleared byte count and an open input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            |=> (count_reg == '0 && s_axis_tready))
        else $error("hasher not restarted after digest");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the SHA-1 stream hasher: directed rows, random messages, idle/stall mixes.
`timescale 1ns / 1ps

// Drives byte transactions into sha1_stream_hasher_top and checks every digest
// word that comes back. A bit-accurate SHA-1 model in this file follows each
// accepted input transaction and queues the five words that a finalizing
// transaction must produce. The monitor pops one queued word per accepted
// output transaction and compares value, position and the last-word flag.
//
// Stimulus runs in two parts:
//   - a short table of hand-picked transactions (empty message, "abc" with the
//     end flag on the last byte and on a separate byteless transaction,
//     single-byte extremes, ignored idle transactions). The well-known digests
//     of "" and "abc" are typed in; other rows use the model.
//   - random messages in four phases, each with its own idle/stall mix and one
//     block-boundary length (55, 56, 63, 64 bytes: one or two pad blocks, full
//     block followed by padding), then short random messages with idle
//     transactions sprinkled in until the phase quota is met.
module tb_top;

    import sha1sh_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_CYC   = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 60;
    localparam int TAIL_CYC    = 20;
    localparam int NUM_PHASES  = 4;
    localparam int NUM_ROWS    = 15;
    localparam int DIGEST_WORDS = 5;

    localparam logic [159:0] DIGEST_EMPTY =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] DIGEST_ABC =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    // Per-phase idle mix (percent of cycles) and boundary message length.
    localparam int SENDER_IDLE [NUM_PHASES]  = '{0, 86, 0, 27};
    localparam int RECV_STALL  [NUM_PHASES]  = '{0, 0, 86, 27};
    localparam int BOUNDARY_LEN [NUM_PHASES] = '{55, 56, 63, 64};

    // One row of the directed table: a single input transaction, plus a typed
    // digest where the row finalizes a message with a well-known hash.
    typedef struct packed {
        logic [7:0]   data;
        logic         has;
        logic         eom;
        logic         pinned;
        logic [159:0] digest;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},         // idle, ignored
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},   // empty message
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},     // "abc", end on last byte
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},         // idle inside a message
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_ABC},     // "abc", end on its own
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},         // single zero byte
        '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},         // single all-ones byte
        '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h7F, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h55, 1'b0, 1'b1, 1'b0, 160'h0}          // end with junk data
    };

    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_word_t;

    logic        clk;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Model state: chaining value, block buffer, running byte count.
    word_t                chain_st [DIGEST_WORDS];
    word_t                block_st [16];
    logic [COUNT_W-1:0]   byte_cnt;

    digest_word_t digest_words_due [$];
    digest_word_t expected_word;

    int sender_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int mismatch_count;
    int items_sent;
    int bytes_sent;
    int messages_sent;
    int words_checked;

    sha1_stream_hasher_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT, which catches a hung hasher.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycle_count, digest_words_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // SHA-1 model
    // ------------------------------------------------------------------

    function automatic word_t rotl(input word_t x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Run the 80-round compression on block_st and add into chain_st.
    task automatic hash_block();
        word_t w [80];
        word_t a, b, c, d, e, f, k, t;
        int    i;
        for (i = 0; i < 16; i++)
            w[i] = block_st[i];
        for (i = 16; i < 80; i++)
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_st[0];
        b = chain_st[1];
        c = chain_st[2];
        d = chain_st[3];
        e = chain_st[4];
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = d ^ (b & (c ^ d));
                k = K_ROUND0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (d & (b | c));
                k = K_ROUND2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_st[0] += a;
        chain_st[1] += b;
        chain_st[2] += c;
        chain_st[3] += d;
        chain_st[4] += e;
    endtask

    // Big-endian byte placement: byte 0 of a word is its top byte.
    task automatic place_byte(input logic [5:0] pos, input logic [7:0] v);
        int sh;
        sh = (3 - int'(pos[1:0])) * 8;
        block_st[pos[5:2]][sh +: 8] = v;
    endtask

    task automatic restart_digest();
        int i;
        for (i = 0; i < DIGEST_WORDS; i++)
            chain_st[i] = INIT_CHAIN[i];
        for (i = 0; i < 16; i++)
            block_st[i] = '0;
        byte_cnt = '0;
    endtask

    // Advance the model by one accepted input transaction; on a finalizing
    // transaction return the 160-bit digest, word 0 in the top bits.
    task automatic absorb_item(input logic [7:0] data, input logic has, input logic eom,
                               output logic done, output logic [159:0] digest);
        logic [63:0] bit_len;
        int          pos;
        int          i;
        done   = 1'b0;
        digest = '0;
        if (has)
        begin
            place_byte(byte_cnt[5:0], data);
            byte_cnt = byte_cnt + 1'b1;
            if (byte_cnt[5:0] == 6'd0)
                hash_block();
        end
        if (eom)
        begin
            bit_len = {byte_cnt, 3'b000};
            pos = int'(byte_cnt[5:0]);
            place_byte(pos[5:0], PAD_MARKER);
            pos++;
            // No room for the length: zero the rest of this block and spill over.
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    place_byte(pos[5:0], 8'h00);
                    pos++;
                end
                hash_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                place_byte(pos[5:0], 8'h00);
                pos++;
            end
            block_st[LEN_HI_WORD] = bit_len[63:32];
            block_st[LEN_LO_WORD] = bit_len[31:0];
            hash_block();
            for (i = 0; i < DIGEST_WORDS; i++)
                digest[159 - 32*i -: 32] = chain_st[i];
            done = 1'b1;
            restart_digest();
        end
    endtask

    task automatic queue_digest(input logic [159:0] digest);
        digest_word_t dw;
        int           i;
        for (i = 0; i < DIGEST_WORDS; i++)
        begin
            dw.word  = digest[159 - 32*i -: 32];
            dw.index = i[2:0];
            dw.last  = (i[2:0] == LAST_OUT);
            digest_words_due.push_back(dw);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Drive one input transaction. Starts at the falling edge, idles at random,
    // then holds tvalid until the rising edge where tready is seen high. tvalid
    // stays high between back-to-back transactions.
    task automatic send_item(input logic [7:0] data, input logic has, input logic eom,
                             input logic pinned, input logic [159:0] pinned_digest);
        logic         done;
        logic [159:0] digest;
        @(negedge clk);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= data;
        s_axis_tuser  <= has;
        s_axis_tlast  <= eom;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_item(data, has, eom, done, digest);
        if (done)
        begin
            queue_digest(pinned ? pinned_digest : digest);
            messages_sent++;
        end
        if (has || eom)
            items_sent++;
        if (has)
            bytes_sent++;
    endtask

    // Send a message of random bytes. The end flag rides on the last byte or
    // on a byteless transaction of its own; idle transactions are mixed in.
    task automatic send_message(input int len, input logic split_end);
        int n;
        for (n = 0; n < len; n++)
        begin
            if ($urandom_range(9, 0) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
            send_item(8'($urandom), 1'b1, !split_end && (n == len - 1), 1'b0, '0);
        end
        if (split_end || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    endtask

    task automatic set_phase(input int p);
        sender_idle_pct = SENDER_IDLE[p];
        recv_stall_pct  = RECV_STALL[p];
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: pick tready fresh at every falling edge.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Monitor: compare every accepted digest word with the oldest one queued.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_words_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digest word %h index %0d",
                                          m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                expected_word = digest_words_due.pop_front();
                words_checked++;
                if (m_axis_tdata !== expected_word.word)
                    report_mismatch($sformatf("word %0d: got %h, want %h",
                                              expected_word.index, m_axis_tdata,
                                              expected_word.word));
                if (m_axis_tuser !== expected_word.index)
                    report_mismatch($sformatf("word index: got %0d, want %0d",
                                              m_axis_tuser, expected_word.index));
                if (m_axis_tlast !== expected_word.last)
                    report_mismatch($sformatf("last flag on word %0d: got %b, want %b",
                                              expected_word.index, m_axis_tlast,
                                              expected_word.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int p;
        int r;
        int phase_start;
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        s_axis_tlast    = 1'b0;
        mismatch_count  = 0;
        items_sent      = 0;
        bytes_sent      = 0;
        messages_sent   = 0;
        words_checked   = 0;
        set_phase(0);
        restart_digest();

        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling on either side.
        for (r = 0; r < NUM_ROWS; r++)
            send_item(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].has, DIRECTED_ROWS[r].eom,
                      DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].digest);

        // Random phases: one block-boundary message, then short messages.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_phase(p);
            phase_start = items_sent;
            send_message(BOUNDARY_LEN[p], p[0]);
            while (items_sent - phase_start < PHASE_ITEMS)
                send_message($urandom_range(16, 0), $urandom_range(3, 0) == 0);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding digest words, then allow a short tail.
        while (digest_words_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);

        $display("checked %0d digest words over %0d messages (%0d bytes, %0d transactions)",
                 words_checked, messages_sent, bytes_sent, items_sent);
        $display("covered empty, split-end and 55/56/63/64-byte messages under four idle mixes");
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/sha1sh_pkg.sv
hw/rtl/sha1sh_core.sv
hw/rtl/sha1_stream_hasher_top.sv
tb/tb_top.sv
